// ===== sv/lobm_pkg.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Limit order book matcher package
// Sizes of the book stores, result kinds, and the command and status types
// that pass between the controller and the datapath.
// ----------------------------------------------------------------------------
package lobm_pkg;

	// Book capacity and field widths.
	localparam int MAX_ORDERS  = 1024;
	localparam int SLOT_W      = $clog2(MAX_ORDERS);
	localparam int CNT_W       = $clog2(MAX_ORDERS + 1);
	localparam int PRICE_TICKS = 4096;
	localparam int PX_W        = $clog2(PRICE_TICKS);
	localparam int LVL_DEPTH   = 2 * PRICE_TICKS;
	localparam int LVL_AW      = $clog2(LVL_DEPTH);
	localparam int ID_SPACE    = 65536;
	localparam int ID_W        = 16;
	localparam int MAP_AW      = $clog2(ID_SPACE);
	localparam int MAP_W       = SLOT_W + 1;
	localparam int CLR_W       = MAP_AW + 1;
	localparam int QTY_W       = 32;
	localparam int MAX_FILLS   = 63;
	localparam int FILL_W      = $clog2(MAX_FILLS + 1);

	typedef enum logic [2:0] {
		K_TRADE,
		K_RESTED,
		K_DONE,
		K_CANCELLED,
		K_NOTFOUND,
		K_FULL,
		K_DUP,
		K_CAP
	} kind_t;

	typedef enum logic [3:0] {
		OP_NONE,
		OP_CLEAR,
		OP_ACCEPT,
		OP_CANCEL_RD,
		OP_CANCEL_DAT,
		OP_RM_RD,
		OP_RM_DAT,
		OP_SCAN,
		OP_MATCH_RD,
		OP_HEAD_DAT,
		OP_SLOT_DAT,
		OP_FILL,
		OP_ADD_RD,
		OP_ADD_DAT,
		OP_EMIT
	} op_t;

	typedef struct packed {
		op_t   op;
		kind_t kind;
	} cmd_t;

	typedef struct packed {
		logic clr_done;
		logic is_cancel;
		logic map_hit;
		logic rem_zero;
		logic can_trade;
		logic cap_hit;
		logic book_full;
		logic fill_empties;
		logic rm_scan;
		logic scan_done;
		logic out_free;
	} stat_t;

endpackage

// ===== sv/lobm_ram.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Generic simple dual-port RAM
// One write port and one read port with registered read data.
// ----------------------------------------------------------------------------
module lobm_ram #(
	parameter int DATA_W = 8,
	parameter int DEPTH  = 16,
	localparam int AW    = $clog2(DEPTH)
) (
	input  logic              clk,
	input  logic              we,
	input  logic [AW-1:0]     waddr,
	input  logic [DATA_W-1:0] wdata,
	input  logic [AW-1:0]     raddr,
	output logic [DATA_W-1:0] rdata
);

	logic [DATA_W-1:0] mem [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
	end

	always_ff @(posedge clk) begin
		rdata <= mem[raddr];
	end

endmodule

// ===== sv/lobm_ctrl.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Limit order book controller
// Sequences the datapath through lookup, matching, unlinking, level scans,
// resting and result beats.
// ----------------------------------------------------------------------------
module lobm_ctrl import lobm_pkg::*; (
	input  logic  clk,
	input  logic  arst_n,
	input  logic  in_valid,
	output logic  in_ready,
	input  stat_t st,
	output cmd_t  cmd
);

	typedef enum logic [3:0] {
		ST_CLR,
		ST_IDLE,
		ST_LOOKUP,
		ST_LOOK_W,
		ST_CAN_DAT,
		ST_RM_RD,
		ST_RM_DAT,
		ST_SCAN,
		ST_MATCH,
		ST_HEAD,
		ST_SLOT,
		ST_FILL,
		ST_TRADE,
		ST_ADD_RD,
		ST_ADD_DAT,
		ST_STATUS
	} state_t;

	state_t state_q, state_d;
	kind_t  kind_q, kind_d;

	assign in_ready = (state_q == ST_IDLE);

	always_comb begin
		state_d  = state_q;
		kind_d   = kind_q;
		cmd.op   = OP_NONE;
		cmd.kind = kind_q;
		unique case (state_q)
			ST_CLR: begin
				cmd.op = OP_CLEAR;
				if (st.clr_done) begin
					state_d = ST_IDLE;
				end
			end
			ST_IDLE: begin
				if (in_valid) begin
					cmd.op  = OP_ACCEPT;
					state_d = ST_LOOKUP;
				end
			end
			ST_LOOKUP: state_d = ST_LOOK_W;
			ST_LOOK_W: begin
				priority if (st.is_cancel && st.map_hit) begin
					cmd.op  = OP_CANCEL_RD;
					state_d = ST_CAN_DAT;
				end else if (st.is_cancel) begin
					kind_d  = K_NOTFOUND;
					state_d = ST_STATUS;
				end else if (st.map_hit) begin
					kind_d  = K_DUP;
					state_d = ST_STATUS;
				end else begin
					state_d = ST_MATCH;
				end
			end
			ST_CAN_DAT: begin
				cmd.op  = OP_CANCEL_DAT;
				state_d = ST_RM_RD;
			end
			ST_RM_RD: begin
				cmd.op  = OP_RM_RD;
				state_d = ST_RM_DAT;
			end
			ST_RM_DAT, ST_SCAN: begin
				cmd.op = (state_q == ST_SCAN) ? OP_SCAN : OP_RM_DAT;
				if ((state_q == ST_RM_DAT && !st.rm_scan) ||
				    (state_q == ST_SCAN && st.scan_done)) begin
					if (st.is_cancel) begin
						kind_d  = K_CANCELLED;
						state_d = ST_STATUS;
					end else begin
						state_d = ST_TRADE;
					end
				end else begin
					state_d = ST_SCAN;
				end
			end
			ST_MATCH: begin
				priority if (st.rem_zero) begin
					kind_d  = K_DONE;
					state_d = ST_STATUS;
				end else if (st.can_trade && !st.cap_hit) begin
					cmd.op  = OP_MATCH_RD;
					state_d = ST_HEAD;
				end else if (st.can_trade) begin
					kind_d  = K_CAP;
					state_d = ST_STATUS;
				end else if (st.book_full) begin
					kind_d  = K_FULL;
					state_d = ST_STATUS;
				end else begin
					state_d = ST_ADD_RD;
				end
			end
			ST_HEAD: begin
				cmd.op  = OP_HEAD_DAT;
				state_d = ST_SLOT;
			end
			ST_SLOT: begin
				cmd.op  = OP_SLOT_DAT;
				state_d = ST_FILL;
			end
			ST_FILL: begin
				cmd.op  = OP_FILL;
				state_d = st.fill_empties ? ST_RM_RD : ST_TRADE;
			end
			ST_TRADE: begin
				cmd.kind = K_TRADE;
				if (st.out_free) begin
					cmd.op  = OP_EMIT;
					state_d = ST_MATCH;
				end
			end
			ST_ADD_RD: begin
				cmd.op  = OP_ADD_RD;
				state_d = ST_ADD_DAT;
			end
			ST_ADD_DAT: begin
				cmd.op  = OP_ADD_DAT;
				kind_d  = K_RESTED;
				state_d = ST_STATUS;
			end
			ST_STATUS: begin
				if (st.out_free) begin
					cmd.op  = OP_EMIT;
					state_d = ST_IDLE;
				end
			end
			default: state_d = ST_IDLE;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_CLR;
			kind_q  <= K_DONE;
		end else begin
			state_q <= state_d;
			kind_q  <= kind_d;
		end
	end

endmodule

// ===== sv/lobm_dp.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Limit order book datapath
// Slot, level, id map and free stack memories, working registers, best
// price tracking and the output register.
// ----------------------------------------------------------------------------
module lobm_dp import lobm_pkg::*; (
	input  logic             clk,
	input  logic             arst_n,
	input  cmd_t             cmd,
	output stat_t            st,
	input  logic             in_mode,
	input  logic [ID_W-1:0]  in_order_id,
	input  logic             in_side,
	input  logic [PX_W-1:0]  in_price,
	input  logic [QTY_W-1:0] in_quantity,
	output logic             out_valid,
	input  logic             out_ready,
	output kind_t            out_kind,
	output logic [ID_W-1:0]  out_buy_id,
	output logic [ID_W-1:0]  out_sell_id,
	output logic [PX_W-1:0]  out_price,
	output logic [QTY_W-1:0] out_qty,
	output logic [PX_W-1:0]  out_best_bid,
	output logic             out_bid_valid,
	output logic [PX_W-1:0]  out_best_ask,
	output logic             out_ask_valid,
	output logic             out_last
);

	// Working registers.
	logic              mode_q, sell_q, side_r_q, scan_side_q, scan_chk_q;
	logic [ID_W-1:0]   id_q, rid_q;
	logic [PX_W-1:0]   px_q, p_r_q, bid_q, ask_q, scan_idx_q, scan_prev_q;
	logic [QTY_W-1:0]  rem_q, sq_q, q_q;
	logic [FILL_W-1:0] nfill_q;
	logic [SLOT_W-1:0] s_q;
	logic              bid_ok_q, ask_ok_q, out_v_q;
	logic [CNT_W-1:0]  stk_cnt_q, fresh_q;
	logic [CLR_W-1:0]  clr_q;

	// Memory ports.
	logic              map_we, used_we, head_we, tail_we, add_we;
	logic              qty_we, next_we, prev_we, stk_we;
	logic [MAP_AW-1:0] map_waddr;
	logic [MAP_W-1:0]  map_wdata, map_rd;
	logic [LVL_AW-1:0] used_waddr, used_raddr, head_waddr, head_raddr;
	logic [LVL_AW-1:0] tail_waddr, tail_raddr;
	logic              used_wdata, used_rd, sside_rd;
	logic [SLOT_W-1:0] head_wdata, head_rd, tail_wdata, tail_rd;
	logic [SLOT_W-1:0] slot_raddr, qty_waddr, next_waddr, next_wdata, next_rd;
	logic [SLOT_W-1:0] prev_waddr, prev_wdata, prev_rd;
	logic [SLOT_W-1:0] stk_waddr, stk_wdata, stk_raddr, stk_rd;
	logic [ID_W-1:0]   sid_rd;
	logic [PX_W-1:0]   sprice_rd;
	logic [QTY_W-1:0]  qty_wdata, sqty_rd;

	// Derived terms.
	logic [LVL_AW-1:0] key_r, key_add;
	logic [PX_W-1:0]   lvl_opp;
	logic [SLOT_W-1:0] s_new, cancel_slot;
	logic              is_head, is_tail, both, rm_best, rm_at_end;
	logic              scan_found, scan_end, scan_idx_end, add_improves, clr_done;

	assign key_r        = {side_r_q, p_r_q};
	assign key_add      = {sell_q, px_q};
	assign lvl_opp      = sell_q ? bid_q : ask_q;
	assign s_new        = (stk_cnt_q != '0) ? stk_rd : fresh_q[SLOT_W-1:0];
	assign cancel_slot  = SLOT_W'(map_rd - MAP_W'(1));
	assign stk_raddr    = SLOT_W'(stk_cnt_q - CNT_W'(1));
	assign is_head      = (head_rd == s_q);
	assign is_tail      = (tail_rd == s_q);
	assign both         = is_head && is_tail;
	assign rm_best      = side_r_q ? (ask_ok_q && ask_q == p_r_q) : (bid_ok_q && bid_q == p_r_q);
	assign rm_at_end    = side_r_q ? (p_r_q == PX_W'(PRICE_TICKS - 1)) : (p_r_q == '0);
	assign scan_found   = scan_chk_q && used_rd;
	assign scan_end     = scan_side_q ? (scan_prev_q == PX_W'(PRICE_TICKS - 1))
	                                  : (scan_prev_q == '0);
	assign scan_idx_end = scan_side_q ? (scan_idx_q == PX_W'(PRICE_TICKS - 1))
	                                  : (scan_idx_q == '0);
	assign add_improves = sell_q ? (!ask_ok_q || px_q < ask_q) : (!bid_ok_q || px_q > bid_q);
	assign clr_done     = (clr_q == CLR_W'(ID_SPACE));

	assign st.clr_done     = clr_done;
	assign st.is_cancel    = mode_q;
	assign st.map_hit      = (map_rd != '0);
	assign st.rem_zero     = (rem_q == '0);
	assign st.can_trade    = sell_q ? (bid_ok_q && px_q <= bid_q) : (ask_ok_q && px_q >= ask_q);
	assign st.cap_hit      = (nfill_q == FILL_W'(MAX_FILLS));
	assign st.book_full    = (stk_cnt_q == '0) && (fresh_q == CNT_W'(MAX_ORDERS));
	assign st.fill_empties = (q_q == sq_q);
	assign st.rm_scan      = both && rm_best && !rm_at_end;
	assign st.scan_done    = scan_found || (scan_chk_q && scan_end);
	assign st.out_free     = !out_v_q || out_ready;

	// Memory address and write selection for each command.
	always_comb begin
		map_we     = 1'b0;
		map_waddr  = id_q;
		map_wdata  = '0;
		used_we    = 1'b0;
		used_waddr = key_r;
		used_wdata = 1'b0;
		used_raddr = key_add;
		head_we    = 1'b0;
		head_waddr = key_r;
		head_wdata = next_rd;
		head_raddr = key_r;
		tail_we    = 1'b0;
		tail_waddr = key_r;
		tail_wdata = prev_rd;
		tail_raddr = key_r;
		slot_raddr = s_q;
		add_we     = 1'b0;
		qty_we     = 1'b0;
		qty_waddr  = s_q;
		qty_wdata  = sq_q - q_q;
		next_we    = 1'b0;
		next_waddr = prev_rd;
		next_wdata = next_rd;
		prev_we    = 1'b0;
		prev_waddr = next_rd;
		prev_wdata = prev_rd;
		stk_we     = 1'b0;
		stk_waddr  = stk_cnt_q[SLOT_W-1:0];
		stk_wdata  = s_q;
		unique case (cmd.op)
			OP_CLEAR: begin
				if (!clr_done) begin
					map_we    = 1'b1;
					map_waddr = clr_q[MAP_AW-1:0];
					if (clr_q < CLR_W'(LVL_DEPTH)) begin
						used_we    = 1'b1;
						used_waddr = clr_q[LVL_AW-1:0];
					end
				end
			end
			OP_CANCEL_RD: slot_raddr = cancel_slot;
			OP_RM_DAT: begin
				map_we    = 1'b1;
				map_waddr = sid_rd;
				stk_we    = 1'b1;
				priority if (both) begin
					used_we = 1'b1;
				end else if (is_head) begin
					head_we = 1'b1;
				end else if (is_tail) begin
					tail_we = 1'b1;
				end else begin
					next_we = 1'b1;
					prev_we = 1'b1;
				end
			end
			OP_SCAN:     used_raddr = {scan_side_q, scan_idx_q};
			OP_MATCH_RD: head_raddr = {~sell_q, lvl_opp};
			OP_HEAD_DAT: slot_raddr = head_rd;
			OP_FILL:     qty_we = 1'b1;
			OP_ADD_RD:   tail_raddr = key_add;
			OP_ADD_DAT: begin
				add_we     = 1'b1;
				qty_we     = 1'b1;
				qty_waddr  = s_new;
				qty_wdata  = rem_q;
				map_we     = 1'b1;
				map_wdata  = MAP_W'(s_new) + MAP_W'(1);
				used_we    = 1'b1;
				used_waddr = key_add;
				used_wdata = 1'b1;
				tail_we    = 1'b1;
				tail_waddr = key_add;
				tail_wdata = s_new;
				prev_we    = 1'b1;
				prev_waddr = s_new;
				prev_wdata = tail_rd;
				if (used_rd) begin
					next_we    = 1'b1;
					next_waddr = tail_rd;
					next_wdata = s_new;
				end else begin
					head_we    = 1'b1;
					head_waddr = key_add;
					head_wdata = s_new;
				end
			end
			default: ;
		endcase
	end

	lobm_ram #(.DATA_W(MAP_W), .DEPTH(ID_SPACE)) u_map (
		.clk(clk), .we(map_we), .waddr(map_waddr), .wdata(map_wdata),
		.raddr(id_q), .rdata(map_rd)
	);
	lobm_ram #(.DATA_W(1), .DEPTH(LVL_DEPTH)) u_used (
		.clk(clk), .we(used_we), .waddr(used_waddr), .wdata(used_wdata),
		.raddr(used_raddr), .rdata(used_rd)
	);
	lobm_ram #(.DATA_W(SLOT_W), .DEPTH(LVL_DEPTH)) u_head (
		.clk(clk), .we(head_we), .waddr(head_waddr), .wdata(head_wdata),
		.raddr(head_raddr), .rdata(head_rd)
	);
	lobm_ram #(.DATA_W(SLOT_W), .DEPTH(LVL_DEPTH)) u_tail (
		.clk(clk), .we(tail_we), .waddr(tail_waddr), .wdata(tail_wdata),
		.raddr(tail_raddr), .rdata(tail_rd)
	);
	lobm_ram #(.DATA_W(ID_W), .DEPTH(MAX_ORDERS)) u_sid (
		.clk(clk), .we(add_we), .waddr(s_new), .wdata(id_q),
		.raddr(slot_raddr), .rdata(sid_rd)
	);
	lobm_ram #(.DATA_W(1), .DEPTH(MAX_ORDERS)) u_sside (
		.clk(clk), .we(add_we), .waddr(s_new), .wdata(sell_q),
		.raddr(slot_raddr), .rdata(sside_rd)
	);
	lobm_ram #(.DATA_W(PX_W), .DEPTH(MAX_ORDERS)) u_sprice (
		.clk(clk), .we(add_we), .waddr(s_new), .wdata(px_q),
		.raddr(slot_raddr), .rdata(sprice_rd)
	);
	lobm_ram #(.DATA_W(QTY_W), .DEPTH(MAX_ORDERS)) u_sqty (
		.clk(clk), .we(qty_we), .waddr(qty_waddr), .wdata(qty_wdata),
		.raddr(slot_raddr), .rdata(sqty_rd)
	);
	lobm_ram #(.DATA_W(SLOT_W), .DEPTH(MAX_ORDERS)) u_snext (
		.clk(clk), .we(next_we), .waddr(next_waddr), .wdata(next_wdata),
		.raddr(slot_raddr), .rdata(next_rd)
	);
	lobm_ram #(.DATA_W(SLOT_W), .DEPTH(MAX_ORDERS)) u_sprev (
		.clk(clk), .we(prev_we), .waddr(prev_waddr), .wdata(prev_wdata),
		.raddr(slot_raddr), .rdata(prev_rd)
	);
	lobm_ram #(.DATA_W(SLOT_W), .DEPTH(MAX_ORDERS)) u_stack (
		.clk(clk), .we(stk_we), .waddr(stk_waddr), .wdata(stk_wdata),
		.raddr(stk_raddr), .rdata(stk_rd)
	);

	// Control state: clearing pass, free slot accounting, best validity,
	// output beat valid.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			clr_q      <= '0;
			stk_cnt_q  <= '0;
			fresh_q    <= '0;
			bid_ok_q   <= 1'b0;
			ask_ok_q   <= 1'b0;
			scan_chk_q <= 1'b0;
			out_v_q    <= 1'b0;
		end else begin
			if (cmd.op == OP_EMIT) begin
				out_v_q <= 1'b1;
			end else if (out_ready) begin
				out_v_q <= 1'b0;
			end
			unique case (cmd.op)
				OP_CLEAR: begin
					if (!clr_done) begin
						clr_q <= clr_q + CLR_W'(1);
					end
				end
				OP_RM_DAT: begin
					stk_cnt_q  <= stk_cnt_q + CNT_W'(1);
					scan_chk_q <= 1'b0;
					if (both && rm_best && rm_at_end) begin
						if (side_r_q) begin
							ask_ok_q <= 1'b0;
						end else begin
							bid_ok_q <= 1'b0;
						end
					end
				end
				OP_SCAN: begin
					scan_chk_q <= 1'b1;
					if (scan_chk_q && !used_rd && scan_end) begin
						if (scan_side_q) begin
							ask_ok_q <= 1'b0;
						end else begin
							bid_ok_q <= 1'b0;
						end
					end
				end
				OP_ADD_DAT: begin
					if (stk_cnt_q != '0) begin
						stk_cnt_q <= stk_cnt_q - CNT_W'(1);
					end else begin
						fresh_q <= fresh_q + CNT_W'(1);
					end
					if (sell_q) begin
						ask_ok_q <= 1'b1;
					end else begin
						bid_ok_q <= 1'b1;
					end
				end
				default: ;
			endcase
		end
	end

	// Working values and result fields.
	always_ff @(posedge clk) begin
		unique case (cmd.op)
			OP_ACCEPT: begin
				mode_q  <= in_mode;
				id_q    <= in_order_id;
				sell_q  <= in_side;
				px_q    <= in_price;
				rem_q   <= in_quantity;
				nfill_q <= '0;
			end
			OP_CANCEL_RD: s_q <= cancel_slot;
			OP_CANCEL_DAT: begin
				side_r_q <= sside_rd;
				p_r_q    <= sprice_rd;
				sq_q     <= sqty_rd;
			end
			OP_RM_DAT: begin
				scan_side_q <= side_r_q;
				scan_idx_q  <= side_r_q ? p_r_q + PX_W'(1) : p_r_q - PX_W'(1);
			end
			OP_SCAN: begin
				scan_prev_q <= scan_idx_q;
				if (!scan_idx_end) begin
					scan_idx_q <= scan_side_q ? scan_idx_q + PX_W'(1)
					                          : scan_idx_q - PX_W'(1);
				end
				if (scan_found) begin
					if (scan_side_q) begin
						ask_q <= scan_prev_q;
					end else begin
						bid_q <= scan_prev_q;
					end
				end
			end
			OP_MATCH_RD: begin
				side_r_q <= ~sell_q;
				p_r_q    <= lvl_opp;
			end
			OP_HEAD_DAT: s_q <= head_rd;
			OP_SLOT_DAT: begin
				rid_q <= sid_rd;
				sq_q  <= sqty_rd;
				q_q   <= (rem_q < sqty_rd) ? rem_q : sqty_rd;
			end
			OP_FILL: begin
				rem_q   <= rem_q - q_q;
				sq_q    <= sq_q - q_q;
				nfill_q <= nfill_q + FILL_W'(1);
			end
			OP_ADD_DAT: begin
				if (add_improves) begin
					if (sell_q) begin
						ask_q <= px_q;
					end else begin
						bid_q <= px_q;
					end
				end
			end
			OP_EMIT: begin
				out_kind      <= cmd.kind;
				out_last      <= (cmd.kind != K_TRADE);
				out_best_bid  <= bid_ok_q ? bid_q : '0;
				out_bid_valid <= bid_ok_q;
				out_best_ask  <= ask_ok_q ? ask_q : '0;
				out_ask_valid <= ask_ok_q;
				if (cmd.kind == K_TRADE) begin
					out_buy_id  <= sell_q ? rid_q : id_q;
					out_sell_id <= sell_q ? id_q : rid_q;
					out_price   <= p_r_q;
				end else begin
					out_buy_id  <= id_q;
					out_sell_id <= '0;
					out_price   <= '0;
				end
				unique case (cmd.kind)
					K_TRADE:                       out_qty <= q_q;
					K_RESTED, K_FULL, K_CAP, K_DUP: out_qty <= rem_q;
					K_CANCELLED:                   out_qty <= sq_q;
					default:                       out_qty <= '0;
				endcase
			end
			default: ;
		endcase
	end

	assign out_valid = out_v_q;

	// Returned slots can never outnumber the slots handed out.
	a_stack_bound: assert property (@(posedge clk) disable iff (!arst_n)
		stk_cnt_q <= fresh_q)
		else $error("free stack holds more slots than were ever allocated");

	// A result beat is only loaded when the output register can take it.
	a_emit_room: assert property (@(posedge clk) disable iff (!arst_n)
		cmd.op == OP_EMIT |-> (!out_v_q || out_ready))
		else $error("output register overwritten while a beat waits");

	// The book must never be left crossed.
	a_uncrossed: assert property (@(posedge clk) disable iff (!arst_n)
		(bid_ok_q && ask_ok_q) |-> (bid_q < ask_q))
		else $error("best bid at or above best ask");

	// No fill beyond the per-order cap.
	a_fill_cap: assert property (@(posedge clk) disable iff (!arst_n)
		cmd.op == OP_FILL |-> nfill_q < FILL_W'(MAX_FILLS))
		else $error("fill count passed its cap");

endmodule

// ===== sv/limit_order_book_matcher.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Limit order book matcher
// Price-time priority book: new limit orders match against the best opposite
// level oldest first, remainders rest, cancels unlink by order id.
// ----------------------------------------------------------------------------
// After reset the block sweeps its id map and level-used memories and
// accepts no beat until that pass is over. It then works on one input beat
// at a time. Each fill reads the best opposite level head and then the
// resting slot before it writes the fill, and unlinks the resting order
// when it leaves the book. When the best bid or best ask level empties,
// the next best level is found by walking the level-used memory one price
// a cycle. These steps follow from the single read port of each book
// memory and its registered read data.
// Every input beat yields any trade beats in fill order and then exactly one
// status beat with tlast high. A result beat waits in the output register
// while the block goes on working, and the block stalls only when a second
// beat is ready and the first has not yet been taken.
// ----------------------------------------------------------------------------
module limit_order_book_matcher import lobm_pkg::*; (
	input  logic         clk,
	input  logic         arst_n,
	input  logic         s_tvalid,
	output logic         s_tready,
	// [15:0] order_id, [16] side, [28:17] price, [60:29] quantity, rest zero
	input  logic [63:0]  s_tdata,
	// [0] mode
	input  logic [0:0]   s_tuser,
	output logic         m_tvalid,
	input  logic         m_tready,
	// [15:0] buy_order_id, [31:16] sell_order_id, [43:32] exec_price,
	// [75:44] exec_quantity, [87:76] best_bid, [88] bid_valid,
	// [100:89] best_ask, [101] ask_valid, rest zero
	output logic [103:0] m_tdata,
	// [2:0] kind
	output logic [2:0]   m_tuser,
	output logic         m_tlast
);

	cmd_t             cmd;
	stat_t            st;
	kind_t            out_kind;
	logic [ID_W-1:0]  out_buy_id, out_sell_id;
	logic [PX_W-1:0]  out_price, out_best_bid, out_best_ask;
	logic [QTY_W-1:0] out_qty;
	logic             out_bid_valid, out_ask_valid;

	// The controller steps through each order; the datapath owns all storage.
	lobm_ctrl u_ctrl (
		.clk      (clk),
		.arst_n   (arst_n),
		.in_valid (s_tvalid),
		.in_ready (s_tready),
		.st       (st),
		.cmd      (cmd)
	);

	lobm_dp u_dp (
		.clk           (clk),
		.arst_n        (arst_n),
		.cmd           (cmd),
		.st            (st),
		.in_mode       (s_tuser[0]),
		.in_order_id   (s_tdata[15:0]),
		.in_side       (s_tdata[16]),
		.in_price      (s_tdata[28:17]),
		.in_quantity   (s_tdata[60:29]),
		.out_valid     (m_tvalid),
		.out_ready     (m_tready),
		.out_kind      (out_kind),
		.out_buy_id    (out_buy_id),
		.out_sell_id   (out_sell_id),
		.out_price     (out_price),
		.out_qty       (out_qty),
		.out_best_bid  (out_best_bid),
		.out_bid_valid (out_bid_valid),
		.out_best_ask  (out_best_ask),
		.out_ask_valid (out_ask_valid),
		.out_last      (m_tlast)
	);

	// Result fields packed from the lowest bit up, padded to whole bytes.
	assign m_tdata = {2'b00, out_ask_valid, out_best_ask, out_bid_valid, out_best_bid,
	                  out_qty, out_price, out_sell_id, out_buy_id};
	assign m_tuser = out_kind;

endmodule

// ===== tb/sv/tb_limit_order_book_matcher.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Limit order book matcher testbench
// Drives new orders and cancels with random gaps, predicts every trade and
// status beat with a behavioural book, and compares each result beat.
// ----------------------------------------------------------------------------
module tb_limit_order_book_matcher;
	import lobm_pkg::*;

	// One input beat as the sender sees it.
	typedef struct {
		logic        cancel;
		logic [15:0] oid;
		logic        sell;
		logic [11:0] px;
		logic [31:0] qty;
		bit          drain;
	} order_t;

	// One result beat: the tdata word, the kind and the last flag.
	typedef struct {
		logic [103:0] data;
		kind_t        kind;
		logic         lst;
	} result_t;

	localparam int IDLE_LIMIT = 200000;

	logic         clk = 1'b0;
	logic         arst_n = 1'b0;
	logic         s_tvalid = 1'b0;
	logic         s_tready;
	logic [63:0]  s_tdata = '0;
	logic [0:0]   s_tuser = '0;
	logic         m_tvalid;
	logic         m_tready = 1'b0;
	logic [103:0] m_tdata;
	logic [2:0]   m_tuser;
	logic         m_tlast;

	limit_order_book_matcher uut (.*);

	always #5 clk = ~clk;

	// Behavioural book: one FIFO of order ids per price level and side.
	int unsigned  lvl_q[2][4096][$];
	int           resting_qty[int];   // order id -> open quantity
	int unsigned  resting_px[int];
	bit           resting_side[int];
	int           open_count;

	order_t  pending_orders[$];
	result_t expected_results[$];
	bit      failed = 1'b0;
	int      used_ids[$];

	// Handshake counts kept by the monitors, followed by the driving blocks.
	int      in_acc_n = 0;
	int      in_seen_n = 0;
	int      out_acc_n = 0;
	int      out_seen_n = 0;

	function automatic bit best_level(input bit sd, output int unsigned lvl);
		if (sd == 1'b0) begin
			for (int i = 4095; i >= 0; i--)
				if (lvl_q[0][i].size() != 0) begin lvl = i; return 1; end
		end else begin
			for (int i = 0; i < 4096; i++)
				if (lvl_q[1][i].size() != 0) begin lvl = i; return 1; end
		end
		lvl = 0;
		return 0;
	endfunction

	function automatic void push_result(input kind_t k, input int unsigned buy,
			input int unsigned sl, input int unsigned px, input logic [31:0] q,
			input logic lst);
		int unsigned bb, ba;
		bit bv, av;
		result_t r;
		bv = best_level(1'b0, bb);
		av = best_level(1'b1, ba);
		r.data = {2'b00, av, ba[11:0], bv, bb[11:0], q, px[11:0], sl[15:0], buy[15:0]};
		r.kind = k;
		r.lst = lst;
		expected_results.push_back(r);
	endfunction

	function automatic bit crosses(input bit sd, input int unsigned p);
		int unsigned l;
		if (sd) return best_level(1'b0, l) && p <= l;
		return best_level(1'b1, l) && p >= l;
	endfunction

	function automatic void unlink_order(input int id);
		int unsigned p;
		bit sd;
		p = resting_px[id];
		sd = resting_side[id];
		foreach (lvl_q[sd][p][i])
			if (lvl_q[sd][p][i] == id) begin
				lvl_q[sd][p].delete(i);
				break;
			end
		resting_qty.delete(id);
		resting_px.delete(id);
		resting_side.delete(id);
		open_count--;
	endfunction

	// Works out every beat an accepted input must produce.
	function automatic void predict_book(input order_t o);
		logic [31:0] rem, q, oq;
		int unsigned lvl;
		int n, rid;
		bit sd;
		rem = o.qty;
		sd = o.sell;
		n = 0;
		if (o.cancel) begin
			if (!resting_qty.exists(o.oid)) begin
				push_result(K_NOTFOUND, o.oid, 0, 0, 0, 1'b1);
			end else begin
				oq = resting_qty[o.oid];
				unlink_order(o.oid);
				push_result(K_CANCELLED, o.oid, 0, 0, oq, 1'b1);
			end
			return;
		end
		if (resting_qty.exists(o.oid)) begin
			push_result(K_DUP, o.oid, 0, 0, rem, 1'b1);
			return;
		end
		while (rem != 0 && n < MAX_FILLS && crosses(sd, o.px)) begin
			void'(best_level(!sd, lvl));
			rid = lvl_q[!sd][lvl][0];
			oq = resting_qty[rid];
			q = (rem < oq) ? rem : oq;
			rem -= q;
			resting_qty[rid] = oq - q;
			if (oq == q) unlink_order(rid);
			if (sd) push_result(K_TRADE, rid, o.oid, lvl, q, 1'b0);
			else    push_result(K_TRADE, o.oid, rid, lvl, q, 1'b0);
			n++;
		end
		if (rem == 0) begin
			push_result(K_DONE, o.oid, 0, 0, 0, 1'b1);
		end else if (crosses(sd, o.px)) begin
			push_result(K_CAP, o.oid, 0, 0, rem, 1'b1);
		end else if (open_count == MAX_ORDERS) begin
			push_result(K_FULL, o.oid, 0, 0, rem, 1'b1);
		end else begin
			lvl_q[sd][o.px].push_back(o.oid);
			resting_qty[o.oid] = rem;
			resting_px[o.oid] = o.px;
			resting_side[o.oid] = sd;
			open_count++;
			push_result(K_RESTED, o.oid, 0, 0, rem, 1'b1);
		end
	endfunction

	function automatic void add_order(input logic cancel, input logic [15:0] id,
			input logic sd, input logic [11:0] px, input logic [31:0] q,
			input bit drain = 1'b0);
		order_t o;
		o.cancel = cancel;
		o.oid = id;
		o.sell = sd;
		o.px = px;
		o.qty = q;
		o.drain = drain;
		pending_orders.push_back(o);
		if (!cancel) used_ids.push_back(id);
	endfunction

	// Sender: a random gap before each beat, then held until accepted.
	int  send_gap = 0;
	always @(negedge clk) begin
		if (arst_n) begin
			if (in_seen_n != in_acc_n) begin
				// accepted at the last rising edge; a new gap starts
				in_seen_n = in_acc_n;
				s_tvalid <= 1'b0;
				send_gap = $urandom_range(0, 7);
				if ($urandom_range(0, 3) == 0) send_gap = 0;
			end else if (!s_tvalid && pending_orders.size() != 0) begin
				if (pending_orders[0].drain && expected_results.size() != 0) begin
					// hold back until every expected beat has arrived
				end else if (send_gap > 0) begin
					send_gap--;
				end else begin
					s_tvalid <= 1'b1;
					s_tuser <= pending_orders[0].cancel;
					s_tdata <= {3'b000, pending_orders[0].qty, pending_orders[0].px,
						pending_orders[0].sell, pending_orders[0].oid};
				end
			end
		end
	end

	// Input monitor: predicts at the edge of acceptance.
	always @(posedge clk) begin
		if (arst_n && s_tvalid && s_tready) begin
			predict_book(pending_orders.pop_front());
			in_acc_n++;
		end
	end

	// Receiver: a random stall on the ready line after each beat taken.
	int recv_gap = 0;
	always @(negedge clk) begin
		if (arst_n) begin
			if (out_seen_n != out_acc_n) begin
				out_seen_n = out_acc_n;
				recv_gap = ($urandom_range(0, 2) == 0) ? 0 : $urandom_range(0, 7);
			end
			if (recv_gap > 0) begin
				recv_gap--;
				m_tready <= 1'b0;
			end else begin
				m_tready <= 1'b1;
			end
		end
	end

	// Output monitor: compares each result beat with the oldest expectation.
	always @(posedge clk) begin
		result_t e;
		if (arst_n && m_tvalid && m_tready) begin
			out_acc_n++;
			if (expected_results.size() == 0) begin
				$display("%0t: unexpected beat tuser=%0d tdata=%h tlast=%b", $realtime,
					m_tuser, m_tdata, m_tlast);
				failed = 1'b1;
			end else begin
				e = expected_results.pop_front();
				if (m_tuser !== e.kind) begin
					$display("%0t: kind expected %0d actual %0d", $realtime, e.kind, m_tuser);
					failed = 1'b1;
				end
				if (m_tdata[15:0] !== e.data[15:0]) begin
					$display("%0t: buy id expected %0d actual %0d", $realtime,
						e.data[15:0], m_tdata[15:0]);
					failed = 1'b1;
				end
				if (m_tdata[31:16] !== e.data[31:16]) begin
					$display("%0t: sell id expected %0d actual %0d", $realtime,
						e.data[31:16], m_tdata[31:16]);
					failed = 1'b1;
				end
				if (m_tdata[43:32] !== e.data[43:32]) begin
					$display("%0t: price expected %0d actual %0d", $realtime,
						e.data[43:32], m_tdata[43:32]);
					failed = 1'b1;
				end
				if (m_tdata[75:44] !== e.data[75:44]) begin
					$display("%0t: quantity expected %0d actual %0d", $realtime,
						e.data[75:44], m_tdata[75:44]);
					failed = 1'b1;
				end
				if (m_tdata[88:76] !== e.data[88:76]) begin
					$display("%0t: best bid expected %h actual %h", $realtime,
						e.data[88:76], m_tdata[88:76]);
					failed = 1'b1;
				end
				if (m_tdata[101:89] !== e.data[101:89]) begin
					$display("%0t: best ask expected %h actual %h", $realtime,
						e.data[101:89], m_tdata[101:89]);
					failed = 1'b1;
				end
				if (m_tdata[103:102] !== 2'b00) begin
					$display("%0t: pad expected 0 actual %b", $realtime, m_tdata[103:102]);
					failed = 1'b1;
				end
				if (m_tlast !== e.lst) begin
					$display("%0t: tlast expected %b actual %b", $realtime, e.lst, m_tlast);
					failed = 1'b1;
				end
			end
		end
	end

	// Watchdog: counts cycles without a beat on either side; the clearing
	// pass after reset and the longest level walks fit well inside it.
	int idle_cycles = 0;
	always @(posedge clk) begin
		if ((s_tvalid && s_tready) || (m_tvalid && m_tready)) idle_cycles <= 0;
		else idle_cycles <= idle_cycles + 1;
		if (idle_cycles >= IDLE_LIMIT) begin
			$display("[FAIL] regression broken");
			$finish;
		end
	end

	// Stimulus and end of run.
	initial begin
		int id;
		int p;
		arst_n = 1'b0;
		repeat (2) @(posedge clk);
		@(negedge clk) arst_n = 1'b1;

		// Directed part: extremes, both sides, most status kinds.
		add_order(1'b0, 16'd0, 1'b0, 12'd100, 32'd0);          // zero quantity: done
		add_order(1'b0, 16'hFFFF, 1'b0, 12'd0, 32'hFFFF_FFFF); // bid at tick zero
		add_order(1'b0, 16'hFFFF, 1'b1, 12'd5, 32'd7);         // duplicate id
		add_order(1'b0, 16'd1, 1'b1, 12'hFFF, 32'd10);         // ask at top tick
		add_order(1'b0, 16'd2, 1'b1, 12'd200, 32'd5);
		add_order(1'b0, 16'd3, 1'b1, 12'd200, 32'd6);          // same level, behind
		add_order(1'b0, 16'd4, 1'b0, 12'd200, 32'd8);          // fills 5, then 3
		add_order(1'b1, 16'd3, 1'b0, 12'd0, 32'd0);            // cancel remainder
		add_order(1'b1, 16'd3, 1'b1, 12'hFFF, 32'hFFFF_FFFF);  // not found now
		add_order(1'b0, 16'd5, 1'b0, 12'hFFF, 32'd20);         // sweeps top ask, rests
		add_order(1'b0, 16'd6, 1'b1, 12'd0, 32'hFFFF_FFFF);    // trades against both bids
		add_order(1'b1, 16'd6, 1'b0, 12'd0, 32'd0, 1'b1);      // not found; sent once all beats are in
		// Fill cap: 64 single-unit asks at one level, then one large buy.
		for (int i = 0; i < 64; i++)
			add_order(1'b0, 16'(100 + i), 1'b1, 12'd50, 32'd1);
		add_order(1'b0, 16'd300, 1'b0, 12'd60, 32'd100, 1'b1);
		add_order(1'b0, 16'd301, 1'b0, 12'd60, 32'd1);          // takes the last one

		// Random part: mostly orders around a narrow price band so they cross,
		// with cancels of live and stale ids and some wide-ranging noise.
		for (int i = 0; i < 150; i++) begin
			p = $urandom_range(0, 9);
			if (p < 2 && used_ids.size() != 0) begin
				add_order(1'b1, 16'(used_ids[$urandom_range(0, used_ids.size() - 1)]),
					1'($urandom_range(0, 1)), 12'($urandom), $urandom);
			end else if (p == 2) begin
				add_order(1'($urandom_range(0, 1)), 16'($urandom),
					1'($urandom_range(0, 1)), 12'($urandom), $urandom, i == 120);
			end else begin
				id = (used_ids.size() != 0 && $urandom_range(0, 15) == 0)
					? used_ids[$urandom_range(0, used_ids.size() - 1)]
					: $urandom_range(6000, 65535);
				add_order(1'b0, 16'(id), 1'($urandom_range(0, 1)),
					12'($urandom_range(2040, 2056)),
					($urandom_range(0, 7) == 0) ? $urandom : $urandom_range(0, 40),
					i == 60);
			end
		end

		wait (pending_orders.size() == 0);
		wait (expected_results.size() == 0);
		repeat (100) @(posedge clk);
		if (!failed) begin
			$display("[ OK ] regression clean");
		end else begin
			$display("[FAIL] regression broken");
		end
		$finish;
	end

endmodule
